### hdl/assert_macros.svh
// Assertion helpers. Both expect clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SSMR_ASSERT_IMPL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
`define SSMR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define SSMR_ASSERT_IMPL(lbl, prop, msg)
`define SSMR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### hdl/ssmr_pkg.sv
package ssmr_pkg;

	localparam int STR_BITS     = 32;
	localparam int SELF_ENTRIES = 64;

	localparam int ADDR_W = $clog2(SELF_ENTRIES);
	localparam int IDX_W  = 6;
	localparam int STR_W  = 32;
	localparam int CFG_W  = 6;
	localparam int RAD_W  = 7;

	// bits of the radius that select erosion steps, and comparison lanes (one per shift)
	localparam int RK    = $clog2(STR_BITS + 1);
	localparam int LANES = 2 * STR_BITS - 1;

	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	localparam logic [ADDR_W-1:0] LAST_ENTRY  = ADDR_W'(SELF_ENTRIES - 1);
	localparam logic [CFG_W-1:0]  R_START_RST = CFG_W'(1);
	localparam logic [CFG_W-1:0]  R_SPAN_RST  = CFG_W'(8);

	localparam logic OP_LOAD = 1'b0;

	typedef enum logic {
		CFG_R_START = 1'b0,
		CFG_R_SPAN  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_LOAD,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [ADDR_W-1:0]   addr;
		logic [STR_BITS-1:0] bits;
		logic [RAD_W-1:0]    r_first;
		logic [RAD_W-1:0]    cap;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST,
		ST_DONE
	} back_state_t;

endpackage

### hdl/self_set_match_radius.sv
// Self-set match radius. A load (opcode 0) writes string_bits into self slot
// entry_index and gives no result; a query (opcode 1) returns the smallest
// radius from r_start up with no common substring of that length between the
// detector and any self entry, or r_start+r_span with capped set when every
// tried length matched. All self slots must be loaded before the first query.
// Items go through a two-deep command queue, so push is accepted while a query
// runs and the queue is not full. A load is written to the self store from the
// idle state of the search engine. A query tests the self entries in order and
// ends after the last one, or, once it reaches the cap, at the entry where it
// does. The engine tests one self entry per cycle through the single read port
// of the self store, and a matching entry holds that port for another test at
// each radius step. One finished result waits in an output register.
// Configuration writes (index 0 r_start, index 1 r_span) are taken every
// cycle.
module self_set_match_radius import ssmr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             opcode,
	input  logic [IDX_W-1:0] entry_index,
	input  logic [STR_W-1:0] string_bits,
	output logic             empty,
	input  logic             pop,
	output logic [RAD_W-1:0] radius,
	output logic             capped,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	cmd_t q_wr_cmd;
	cmd_t q_rd_cmd;

	ssmr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.entry_index (entry_index),
		.string_bits (string_bits),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_wr_cmd)
	);

	ssmr_cmd_fifo u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rd_cmd (q_rd_cmd),
		.empty  (q_empty)
	);

	ssmr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_cmd   (q_rd_cmd),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.radius  (radius),
		.capped  (capped)
	);

endmodule

### hdl/ssmr_cmd_fifo.sv
module ssmr_cmd_fifo import ssmr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic empty
);

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	function automatic logic [CMD_PTR_W-1:0] ptr_next(input logic [CMD_PTR_W-1:0] p);
		if (p == CMD_PTR_W'(CMD_DEPTH - 1))
			return '0;
		return p + CMD_PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CMD_CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CMD_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

### hdl/ssmr_front.sv
module ssmr_front import ssmr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             opcode,
	input  logic [IDX_W-1:0] entry_index,
	input  logic [STR_W-1:0] string_bits,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             q_full,
	output logic             q_push,
	output cmd_t             q_cmd
);

	logic [CFG_W-1:0] r_start_q;
	logic [CFG_W-1:0] r_span_q;
	logic             accept;
	logic             in_range;
	cmd_kind_t        kind;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_start_q <= R_START_RST;
			r_span_q  <= R_SPAN_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_R_START)
				r_start_q <= cfg_data;
			else
				r_span_q <= cfg_data;
		end
	end

	assign full     = q_full;
	assign accept   = push & ~q_full;
	assign in_range = (32'(entry_index) < 32'(SELF_ENTRIES));
	assign kind     = (opcode == OP_LOAD) ? CMD_LOAD : CMD_QUERY;

	// loads to a slot past the store are accepted and dropped here
	assign q_push = accept & ((kind == CMD_QUERY) | in_range);

	always_comb begin
		q_cmd.kind    = kind;
		q_cmd.addr    = ADDR_W'(entry_index);
		q_cmd.bits    = STR_BITS'(string_bits);
		q_cmd.r_first = RAD_W'(r_start_q);
		q_cmd.cap     = RAD_W'(r_start_q) + RAD_W'(r_span_q);
	end

endmodule

### hdl/ssmr_ram.sv
module ssmr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/ssmr_match.sv
module ssmr_match import ssmr_pkg::*; (
	input  logic [STR_BITS-1:0] det,
	input  logic [STR_BITS-1:0] ref_bits,
	input  logic [RAD_W-1:0]    r,
	output logic                hit
);

	logic [LANES-1:0] lane_hit;

	// One lane per relative shift of the two strings. A lane holds the per-bit
	// equality over the overlap; a common substring of length r is a run of r ones.
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		localparam int D   = l - (STR_BITS - 1);
		localparam int LEN = (D < 0) ? STR_BITS + D : STR_BITS - D;
		localparam logic [STR_BITS-1:0] MASK = {STR_BITS{1'b1}} >> (STR_BITS - LEN);

		logic [STR_BITS-1:0] eq;
		logic                lh;

		if (D >= 0) begin : g_pos
			assign eq = ~(det ^ (ref_bits >> D)) & MASK;
		end else begin : g_neg
			assign eq = ~((det >> (-D)) ^ ref_bits) & MASK;
		end

		// erosion by r: p steps through runs of 2^k, w collects the set bits of r;
		// the first set bit seeds w directly so runs ending at the top bit survive
		always_comb begin
			logic [STR_BITS-1:0] p;
			logic [STR_BITS-1:0] w;
			logic                seed;
			p    = eq;
			w    = '1;
			seed = 1'b1;
			for (int k = 0; k < RK; k++) begin
				if (r[k]) begin
					w    = seed ? p : (p & (w >> (1 << k)));
					seed = 1'b0;
				end
				p = p & (p >> (1 << k));
			end
			lh = |w;
		end

		assign lane_hit[l] = lh;
	end

	always_comb begin
		if (r == '0)
			hit = 1'b1;
		else if (r > RAD_W'(STR_BITS))
			hit = 1'b0;
		else
			hit = |lane_hit;
	end

endmodule

### hdl/ssmr_back.sv
`include "assert_macros.svh"

module ssmr_back import ssmr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  cmd_t             q_cmd,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [RAD_W-1:0] radius,
	output logic             capped
);

	back_state_t         state_q;
	back_state_t         state_d;
	logic [STR_BITS-1:0] det_q;
	logic [RAD_W-1:0]    r_q;
	logic [RAD_W-1:0]    cap_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic                hit_q;
	logic                out_valid_q;
	logic [RAD_W-1:0]    radius_q;
	logic                capped_q;

	logic                ram_we;
	logic                ram_rd;
	logic [ADDR_W-1:0]   ram_rd_addr;
	logic [STR_BITS-1:0] ram_rd_data;
	logic                hit;
	logic [RAD_W-1:0]    r_inc;
	logic                start;
	logic                bump;
	logic                advance;
	logic                out_pop;
	logic                out_free;
	logic                out_load;

	ssmr_ram #(
		.WIDTH (STR_BITS),
		.DEPTH (SELF_ENTRIES)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (q_cmd.addr),
		.wr_data (q_cmd.bits),
		.rd_en   (ram_rd),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	ssmr_match u_match (
		.det      (det_q),
		.ref_bits (ram_rd_data),
		.r        (r_q),
		.hit      (hit)
	);

	assign r_inc    = r_q + RAD_W'(1);
	assign out_pop  = pop & out_valid_q;
	assign out_free = ~out_valid_q | out_pop;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty && q_cmd.kind == CMD_QUERY)
					state_d = ST_TEST;
			end
			ST_TEST: begin
				if (hit) begin
					if (r_inc == cap_q)
						state_d = ST_DONE;
				end else if (ptr_q == LAST_ENTRY) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// A match keeps the same entry and tries the next radius; no match moves on.
	always_comb begin
		q_pop    = 1'b0;
		ram_we   = 1'b0;
		start    = 1'b0;
		bump     = 1'b0;
		advance  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_pop  = ~q_empty;
				ram_we = ~q_empty & (q_cmd.kind == CMD_LOAD);
				start  = ~q_empty & (q_cmd.kind == CMD_QUERY);
			end
			ST_TEST: begin
				bump    = hit;
				advance = ~hit & (ptr_q != LAST_ENTRY);
			end
			ST_DONE: begin
				out_load = out_free;
			end
			default: ;
		endcase
		ram_rd      = start | advance;
		ram_rd_addr = start ? '0 : ptr_q + ADDR_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start)
				ptr_q <= '0;
			else if (advance)
				ptr_q <= ptr_q + ADDR_W'(1);
			if (start)
				hit_q <= 1'b0;
			else if (bump && r_inc == cap_q)
				hit_q <= 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			det_q <= q_cmd.bits;
			r_q   <= q_cmd.r_first;
			cap_q <= q_cmd.cap;
		end else if (bump) begin
			r_q <= r_inc;
		end
		if (out_load) begin
			radius_q <= r_q;
			capped_q <= hit_q;
		end
	end

	assign empty  = ~out_valid_q;
	assign radius = radius_q;
	assign capped = capped_q;

	`SSMR_ASSERT_IMPL(a_bump_step, (state_q == ST_TEST && hit && r_inc != cap_q) |=> (state_q == ST_TEST && r_q == $past(r_inc)), "radius did not step by one on a match")
	`SSMR_ASSERT_IMPL(a_bump_hold, (state_q == ST_TEST && hit) |=> $stable(ptr_q), "entry pointer moved on a match")
	`SSMR_ASSERT_IMPL(a_cap_value, (state_q == ST_DONE && hit_q) |-> (r_q == cap_q), "capped search ended off the cap")
	`SSMR_ASSERT_NEVER(a_cap_overrun, state_q == ST_TEST && hit_q, "search kept running past the cap")
	`SSMR_ASSERT_IMPL(a_result_load, out_load |=> (!empty && radius == $past(r_q)), "result register not loaded")

endmodule
